>>> rtl/lir_pkg.sv
// Shared constants for the linear interpolation resampler.
package lir_pkg;

  // Width of every configuration register.
  localparam int REG_W = 24;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LENGTH = 2'd2;

  // Reset values of the block length registers.
  localparam logic [REG_W-1:0] IN_LENGTH_RESET  = 24'd1;
  localparam logic [REG_W-1:0] OUT_LENGTH_RESET = 24'd1;

endpackage

>>> rtl/lir_interp.sv
// Shared interpolation unit: registered multiply, then add and round toward zero.
module lir_interp #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] prev,
  input  logic signed [SAMPLE_BITS-1:0] cur,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  logic signed [DIFF_W-1:0] diff;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] num;
  logic signed [PROD_W-1:0] quot;

  // Difference between the two neighbouring samples and the signed fraction.
  assign diff   = DIFF_W'(cur) - DIFF_W'(prev);
  assign frac_s = signed'({1'b0, frac});

  // The product is registered before the accumulate step.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(diff) * PROD_W'(frac_s);
    end
  end

  // prev * 1.0 + product, then divide by 1.0 with truncation toward zero.
  always_comb begin
    num  = (PROD_W'(prev) <<< FRAC_BITS) + prod;
    quot = num >>> FRAC_BITS;
    if (num[PROD_W-1] && (|num[FRAC_BITS-1:0])) begin
      quot = quot + PROD_W'(1);
    end
  end

  assign result = quot[SAMPLE_BITS-1:0];

endmodule

>>> rtl/linear_interp_resampler.sv
// Top level of the linear interpolation sample rate converter.
// After an input transaction is accepted the block stays busy until it returns to idle: the
// first input of a block skips the interpolation loop, each interpolated output passes the
// loop and add states, each output past the per-input cap passes the loop state only and each
// repeated final sample passes the repeat state; output back-pressure holds the block longer.
// It takes no new input while busy, set by the shared multiplier and the single output register.
// Reset (rst, synchronous) restores the configuration and control registers and clears all block counters.
module linear_interp_resampler #(
  parameter int SAMPLE_BITS  = 24,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lir_pkg::REG_W-1:0]            cfg_data,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // sample_out
  output logic                                 m_axis_tlast
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int REG_W   = lir_pkg::REG_W;
  localparam int POS_W   = REG_W + 1;
  localparam int N_W     = $clog2(MAX_UPSAMPLE + 1);
  localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOP   = 5'b00010,
    S_ADD    = 5'b00100,
    S_REPEAT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [REG_W-1:0] step;
  logic [REG_W-1:0] in_length;
  logic [REG_W-1:0] out_length;

  // Block state
  logic signed [SAMPLE_BITS-1:0] prev_sample;
  logic [POS_W-1:0]              rel_position;
  logic [REG_W-1:0]              input_count;
  logic [REG_W-1:0]              output_count;

  // Per-transaction working registers
  logic signed [SAMPLE_BITS-1:0] cur;
  logic [REG_W-1:0]              step_eff;
  logic                          is_last;
  logic                          last_pend;
  logic [N_W-1:0]                n_cnt;

  // Output register
  logic [SAMPLE_BITS-1:0]        out_data;
  logic                          out_valid;
  logic                          out_last;

  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic                          mul_en;
  logic                          loop_go;
  logic                          cap_room;
  logic                          cap_more;
  logic                          len_room;
  logic                          len_more;
  logic [POS_W-1:0]              rel_sum;
  logic                          last_now;
  logic signed [SAMPLE_BITS-1:0] interp_val;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'(out_data);
  assign m_axis_tlast  = out_last;

  // Loop conditions and look-ahead for the final result of this transaction.
  assign cap_room = n_cnt < N_W'(MAX_UPSAMPLE);
  assign cap_more = n_cnt < N_W'(MAX_UPSAMPLE - 1);
  assign len_room = output_count < out_length;
  assign len_more = ({1'b0, output_count} + POS_W'(1)) < {1'b0, out_length};
  assign rel_sum  = rel_position + {1'b0, step_eff};
  assign loop_go  = len_room && (rel_position < ONE_POS);
  assign mul_en   = (state == S_LOOP) && loop_go && cap_room;
  assign last_now = !(cap_more && len_more && ((rel_sum < ONE_POS) || is_last));

  // A new result enters the output register in this cycle.
  assign out_load = out_free && ((state == S_ADD) ||
                    ((state == S_REPEAT) && is_last && len_room && cap_room));

  lir_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk    (clk),
    .en     (mul_en),
    .prev   (prev_sample),
    .cur    (cur),
    .frac   (rel_position[FRAC_BITS-1:0]),
    .result (interp_val)
  );

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= REG_W'(ONE_POS);
      in_length  <= lir_pkg::IN_LENGTH_RESET;
      out_length <= lir_pkg::OUT_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lir_pkg::CFG_STEP:       step       <= cfg_data;
        lir_pkg::CFG_IN_LENGTH:  in_length  <= cfg_data;
        lir_pkg::CFG_OUT_LENGTH: out_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer over the shared interpolation unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_sample  <= '0;
      rel_position <= '0;
      input_count  <= '0;
      output_count <= '0;
      n_cnt        <= '0;
      is_last      <= 1'b0;
      last_pend    <= 1'b0;
      out_valid    <= 1'b0;
      out_last     <= 1'b0;
    end else begin
      // The output register empties when its transaction completes and nothing new enters.
      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur      <= s_axis_tdata[SAMPLE_BITS-1:0];
            step_eff <= (step == '0) ? REG_W'(1) : step;
            is_last  <= ({1'b0, input_count} + POS_W'(1)) >= {1'b0, in_length};
            n_cnt    <= '0;
            state    <= (input_count != '0) ? S_LOOP : S_REPEAT;
          end
        end

        S_LOOP: begin
          if (loop_go) begin
            rel_position <= rel_sum;
            output_count <= output_count + REG_W'(1);
            if (cap_room) begin
              last_pend <= last_now;
              n_cnt     <= n_cnt + N_W'(1);
              state     <= S_ADD;
            end
          end else begin
            state <= S_REPEAT;
          end
        end

        S_ADD: begin
          if (out_free) begin
            out_data  <= interp_val;
            out_last  <= last_pend;
            out_valid <= 1'b1;
            state     <= S_LOOP;
          end
        end

        S_REPEAT: begin
          // Pending outputs repeat the final sample of the block.
          if (is_last && len_room && cap_room) begin
            if (out_free) begin
              out_data     <= cur;
              out_last     <= !(cap_more && len_more);
              out_valid    <= 1'b1;
              output_count <= output_count + REG_W'(1);
              n_cnt        <= n_cnt + N_W'(1);
            end
          end else begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          prev_sample <= cur;
          if (is_last) begin
            rel_position <= '0;
            input_count  <= '0;
            output_count <= '0;
          end else begin
            if (input_count != '0) begin
              rel_position <= (rel_position >= ONE_POS) ? (rel_position - ONE_POS) : '0;
            end
            input_count <= input_count + REG_W'(1);
          end
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Never more results per transaction than the cap allows.
  a_cap_bound: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= N_W'(MAX_UPSAMPLE))
    else $error("result count exceeds the per-input cap");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && (state == S_ADD)) |=> (state == S_ADD))
    else $error("output register overwritten while stalled");

  // The end of a block clears every block counter.
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && is_last) |=>
      ((input_count == '0) && (output_count == '0) && (rel_position == '0)))
    else $error("block counters not cleared at block end");
`endif

endmodule
